@@ sv/klfs_pkg.sv @@
// Types and constants shared by the keyed list blocks.
package klfs_pkg;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_DELETE = 3'd1;
   localparam logic [2:0] CMD_LIST   = 3'd2;
   localparam logic [2:0] CMD_YEAR   = 3'd3;
   localparam logic [2:0] CMD_COURSE = 3'd4;
   localparam logic [2:0] CMD_SEX    = 3'd5;

   localparam logic [2:0] RSP_ADDED     = 3'd0;
   localparam logic [2:0] RSP_DUPLICATE = 3'd1;
   localparam logic [2:0] RSP_FULL      = 3'd2;
   localparam logic [2:0] RSP_DELETED   = 3'd3;
   localparam logic [2:0] RSP_NOT_FOUND = 3'd4;
   localparam logic [2:0] RSP_EMPTY     = 3'd5;
   localparam logic [2:0] RSP_RECORD    = 3'd6;
   localparam logic [2:0] RSP_NO_MATCH  = 3'd7;

   typedef struct packed {
      logic [2:0]  command;
      logic [26:0] key_id;
      logic [3:0]  year_level;
      logic        sex_code;
      logic [1:0]  course_code;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [26:0] rec_id;
      logic [3:0]  rec_year;
      logic        rec_sex;
      logic [1:0]  rec_course;
      logic [2:0]  slot;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [26:0] key_id;
      logic [3:0]  year_level;
      logic        sex_code;
      logic [1:0]  course_code;
   } rec_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_READ,
      SRC_PEND,
      SRC_INPUT
   } rsp_src_type;

   typedef enum logic {
      RD_CURSOR,
      RD_FREE
   } rd_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_READ,
      S_CHECK,
      S_ALLOC_RD,
      S_ALLOC_WR,
      S_ALLOC_LINK,
      S_UNLINK,
      S_RELEASE,
      S_FINISH,
      S_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic        cap_req;
      logic        init_walk;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        advance;
      logic        pend_load;
      logic        alloc_take;
      logic        link_tail;
      logic        unlink;
      logic        release_slot;
      logic        rsp_load;
      logic [2:0]  rsp_status;
      rsp_src_type rsp_src;
      logic        rsp_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] command;
      logic       head_null;
      logic       free_null;
      logic       link_null;
      logic       key_hit;
      logic       field_hit;
      logic       pend_valid;
      logic       out_free;
   } ctrl_sts_type;

endpackage

@@ sv/klfs_ctrl.sv @@
// Command sequencer for the keyed list: walks, allocation, unlinking and result issue.
module klfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  klfs_pkg::ctrl_sts_type sts,
   output klfs_pkg::ctrl_cmd_type cmd
);

   klfs_pkg::fsm_state_type state_ff, state_in;
   logic [2:0]              emit_status_ff, emit_status_in;
   klfs_pkg::rsp_src_type   emit_src_ff, emit_src_in;
   logic                    is_ins, is_del, is_walk, stall;

   always_comb begin
      is_ins  = (sts.command == klfs_pkg::CMD_INSERT);
      is_del  = (sts.command == klfs_pkg::CMD_DELETE);
      is_walk = (sts.command == klfs_pkg::CMD_LIST) || (sts.command == klfs_pkg::CMD_YEAR) ||
                (sts.command == klfs_pkg::CMD_COURSE) || (sts.command == klfs_pkg::CMD_SEX);
      stall   = sts.field_hit && sts.pend_valid && !sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= klfs_pkg::S_IDLE;
         emit_status_ff <= klfs_pkg::RSP_EMPTY;
         emit_src_ff    <= klfs_pkg::SRC_NONE;
      end else begin
         state_ff       <= state_in;
         emit_status_ff <= emit_status_in;
         emit_src_ff    <= emit_src_in;
      end
   end

   // next state
   always_comb begin
      state_in       = state_ff;
      emit_status_in = emit_status_ff;
      emit_src_in    = emit_src_ff;
      unique case (state_ff)
         klfs_pkg::S_IDLE: begin
            if (req_valid) state_in = klfs_pkg::S_START;
         end
         klfs_pkg::S_START: begin
            priority if (!(is_ins || is_del || is_walk)) begin
               state_in = klfs_pkg::S_IDLE;
            end else if (sts.head_null && is_ins) begin
               state_in = klfs_pkg::S_ALLOC_RD;
            end else if (sts.head_null) begin
               state_in       = klfs_pkg::S_EMIT;
               emit_status_in = klfs_pkg::RSP_EMPTY;
               emit_src_in    = klfs_pkg::SRC_NONE;
            end else begin
               state_in = klfs_pkg::S_READ;
            end
         end
         klfs_pkg::S_READ: begin
            state_in = klfs_pkg::S_CHECK;
         end
         klfs_pkg::S_CHECK: begin
            priority if (is_ins && sts.key_hit) begin
               state_in       = klfs_pkg::S_EMIT;
               emit_status_in = klfs_pkg::RSP_DUPLICATE;
               emit_src_in    = klfs_pkg::SRC_READ;
            end else if (is_del && sts.key_hit) begin
               state_in = klfs_pkg::S_UNLINK;
            end else if (is_walk && stall) begin
               state_in = klfs_pkg::S_CHECK;
            end else if (!sts.link_null) begin
               state_in = klfs_pkg::S_READ;
            end else if (is_ins) begin
               state_in = klfs_pkg::S_ALLOC_RD;
            end else if (is_del) begin
               state_in       = klfs_pkg::S_EMIT;
               emit_status_in = klfs_pkg::RSP_NOT_FOUND;
               emit_src_in    = klfs_pkg::SRC_NONE;
            end else begin
               state_in = klfs_pkg::S_FINISH;
            end
         end
         klfs_pkg::S_ALLOC_RD: begin
            if (sts.free_null) begin
               state_in       = klfs_pkg::S_EMIT;
               emit_status_in = klfs_pkg::RSP_FULL;
               emit_src_in    = klfs_pkg::SRC_NONE;
            end else begin
               state_in = klfs_pkg::S_ALLOC_WR;
            end
         end
         klfs_pkg::S_ALLOC_WR: begin
            state_in = klfs_pkg::S_ALLOC_LINK;
         end
         klfs_pkg::S_ALLOC_LINK: begin
            state_in       = klfs_pkg::S_EMIT;
            emit_status_in = klfs_pkg::RSP_ADDED;
            emit_src_in    = klfs_pkg::SRC_INPUT;
         end
         klfs_pkg::S_UNLINK: begin
            state_in = klfs_pkg::S_RELEASE;
         end
         klfs_pkg::S_RELEASE: begin
            state_in       = klfs_pkg::S_EMIT;
            emit_status_in = klfs_pkg::RSP_DELETED;
            emit_src_in    = klfs_pkg::SRC_READ;
         end
         klfs_pkg::S_FINISH, klfs_pkg::S_EMIT: begin
            if (sts.out_free) state_in = klfs_pkg::S_IDLE;
         end
         default: begin
            state_in = klfs_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = klfs_pkg::RD_CURSOR;
      cmd.rsp_src    = klfs_pkg::SRC_NONE;
      cmd.rsp_status = klfs_pkg::RSP_RECORD;
      req_ready      = 1'b0;
      unique case (state_ff)
         klfs_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.cap_req = req_valid;
         end
         klfs_pkg::S_START: begin
            cmd.init_walk = 1'b1;
         end
         klfs_pkg::S_READ: begin
            cmd.rd_en = 1'b1;
         end
         klfs_pkg::S_CHECK: begin
            if (is_walk) begin
               if (!stall) begin
                  cmd.advance   = 1'b1;
                  cmd.pend_load = sts.field_hit;
                  if (sts.field_hit && sts.pend_valid) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = klfs_pkg::RSP_RECORD;
                     cmd.rsp_src    = klfs_pkg::SRC_PEND;
                     cmd.rsp_last   = 1'b0;
                  end
               end
            end else begin
               cmd.advance = !sts.key_hit;
            end
         end
         klfs_pkg::S_ALLOC_RD: begin
            cmd.rd_en  = !sts.free_null;
            cmd.rd_sel = klfs_pkg::RD_FREE;
         end
         klfs_pkg::S_ALLOC_WR: begin
            cmd.alloc_take = 1'b1;
         end
         klfs_pkg::S_ALLOC_LINK: begin
            cmd.link_tail = 1'b1;
         end
         klfs_pkg::S_UNLINK: begin
            cmd.unlink = 1'b1;
         end
         klfs_pkg::S_RELEASE: begin
            cmd.release_slot = 1'b1;
         end
         klfs_pkg::S_FINISH: begin
            cmd.rsp_load = sts.out_free;
            cmd.rsp_last = 1'b1;
            if (sts.pend_valid) begin
               cmd.rsp_status = klfs_pkg::RSP_RECORD;
               cmd.rsp_src    = klfs_pkg::SRC_PEND;
            end else begin
               cmd.rsp_status = klfs_pkg::RSP_NO_MATCH;
               cmd.rsp_src    = klfs_pkg::SRC_NONE;
            end
         end
         klfs_pkg::S_EMIT: begin
            cmd.rsp_load   = sts.out_free;
            cmd.rsp_last   = 1'b1;
            cmd.rsp_status = emit_status_ff;
            cmd.rsp_src    = emit_src_ff;
         end
         default: begin
            cmd.rsp_load = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/klfs_datapath.sv @@
// Slot stores, list and free pointers, walk cursor, pending match and result register.
module klfs_datapath #(
   parameter int SLOTS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  klfs_pkg::req_type      req_data,
   input  klfs_pkg::ctrl_cmd_type cmd,
   output klfs_pkg::ctrl_sts_type sts,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output klfs_pkg::rsp_type      rsp_data
);

   localparam int SW = $clog2(SLOTS);

   typedef logic [SW:0] ptr_type;

   localparam ptr_type PTR_NULL   = {1'b1, {SW{1'b0}}};
   localparam ptr_type FREE_RESET = {1'b0, SW'(SLOTS - 1)};

   klfs_pkg::req_type req_ff;
   ptr_type           cur_ff, cur_in, prev_ff, prev_in;
   ptr_type           head_ff, head_in, free_ff, free_in;
   ptr_type           link_rd_ff, link_dflt;
   klfs_pkg::rec_type rec_rd_ff;
   klfs_pkg::rec_type rec_mem_ff [SLOTS];
   ptr_type           link_mem_ff [SLOTS];
   logic [SLOTS-1:0]  link_vld_ff;
   logic              pend_valid_ff, pend_valid_in;
   klfs_pkg::rec_type pend_rec_ff;
   ptr_type           pend_slot_ff;
   klfs_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]     rd_idx, link_wa;
   logic              link_we;
   ptr_type           link_wd;

   always_ff @(posedge clock) begin
      if (cmd.cap_req) req_ff <= req_data;
   end

   // read port
   always_comb begin
      rd_idx    = (cmd.rd_sel == klfs_pkg::RD_FREE) ? free_ff[SW-1:0] : cur_ff[SW-1:0];
      link_dflt = (rd_idx == '0) ? PTR_NULL : {1'b0, rd_idx - SW'(1)};
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rec_rd_ff  <= rec_mem_ff[rd_idx];
         link_rd_ff <= link_vld_ff[rd_idx] ? link_mem_ff[rd_idx] : link_dflt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc_take) begin
         rec_mem_ff[free_ff[SW-1:0]] <= '{key_id:      req_ff.key_id,
                                          year_level:  req_ff.year_level,
                                          sex_code:    req_ff.sex_code,
                                          course_code: req_ff.course_code};
      end
   end

   // link write port
   always_comb begin
      link_we = 1'b0;
      link_wa = '0;
      link_wd = PTR_NULL;
      priority if (cmd.alloc_take) begin
         link_we = 1'b1;
         link_wa = free_ff[SW-1:0];
         link_wd = PTR_NULL;
      end else if (cmd.link_tail && !head_ff[SW]) begin
         link_we = 1'b1;
         link_wa = prev_ff[SW-1:0];
         link_wd = cur_ff;
      end else if (cmd.unlink && !prev_ff[SW]) begin
         link_we = 1'b1;
         link_wa = prev_ff[SW-1:0];
         link_wd = link_rd_ff;
      end else if (cmd.release_slot) begin
         link_we = 1'b1;
         link_wa = cur_ff[SW-1:0];
         link_wd = free_ff;
      end else begin
         link_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem_ff[link_wa] <= link_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (link_we) begin
         link_vld_ff[link_wa] <= 1'b1;
      end
   end

   // pointers
   always_comb begin
      cur_in  = cur_ff;
      prev_in = prev_ff;
      head_in = head_ff;
      free_in = free_ff;
      if (cmd.init_walk) begin
         cur_in  = head_ff;
         prev_in = PTR_NULL;
      end
      if (cmd.advance) begin
         prev_in = cur_ff;
         cur_in  = link_rd_ff;
      end
      if (cmd.alloc_take) begin
         cur_in  = free_ff;
         free_in = link_rd_ff;
      end
      if (cmd.link_tail && head_ff[SW]) head_in = cur_ff;
      if (cmd.unlink && prev_ff[SW]) head_in = link_rd_ff;
      if (cmd.release_slot) free_in = cur_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= PTR_NULL;
         prev_ff <= PTR_NULL;
         head_ff <= PTR_NULL;
         free_ff <= FREE_RESET;
      end else begin
         cur_ff  <= cur_in;
         prev_ff <= prev_in;
         head_ff <= head_in;
         free_ff <= free_in;
      end
   end

   // pending match
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.init_walk) pend_valid_in = 1'b0;
      if (cmd.pend_load) pend_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_rec_ff  <= rec_rd_ff;
         pend_slot_ff <= cur_ff;
      end
   end

   // result register
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = cmd.rsp_status;
      rsp_in.last   = cmd.rsp_last;
      unique case (cmd.rsp_src)
         klfs_pkg::SRC_READ: begin
            rsp_in.rec_id     = rec_rd_ff.key_id;
            rsp_in.rec_year   = rec_rd_ff.year_level;
            rsp_in.rec_sex    = rec_rd_ff.sex_code;
            rsp_in.rec_course = rec_rd_ff.course_code;
            rsp_in.slot       = 3'(cur_ff[SW-1:0]);
         end
         klfs_pkg::SRC_PEND: begin
            rsp_in.rec_id     = pend_rec_ff.key_id;
            rsp_in.rec_year   = pend_rec_ff.year_level;
            rsp_in.rec_sex    = pend_rec_ff.sex_code;
            rsp_in.rec_course = pend_rec_ff.course_code;
            rsp_in.slot       = 3'(pend_slot_ff[SW-1:0]);
         end
         klfs_pkg::SRC_INPUT: begin
            rsp_in.rec_id     = req_ff.key_id;
            rsp_in.rec_year   = req_ff.year_level;
            rsp_in.rec_sex    = req_ff.sex_code;
            rsp_in.rec_course = req_ff.course_code;
            rsp_in.slot       = 3'(cur_ff[SW-1:0]);
         end
         default: begin
            rsp_in.slot = '0;
         end
      endcase
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to the sequencer
   always_comb begin
      sts            = '0;
      sts.command    = req_ff.command;
      sts.head_null  = head_ff[SW];
      sts.free_null  = free_ff[SW];
      sts.link_null  = link_rd_ff[SW];
      sts.key_hit    = (rec_rd_ff.key_id == req_ff.key_id);
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = ~rsp_valid_ff | rsp_ready;
      unique case (req_ff.command)
         klfs_pkg::CMD_LIST:   sts.field_hit = 1'b1;
         klfs_pkg::CMD_YEAR:   sts.field_hit = (rec_rd_ff.year_level == req_ff.year_level);
         klfs_pkg::CMD_COURSE: sts.field_hit = (rec_rd_ff.course_code == req_ff.course_code);
         klfs_pkg::CMD_SEX:    sts.field_hit = (rec_rd_ff.sex_code == req_ff.sex_code);
         default:              sts.field_hit = 1'b0;
      endcase
   end

endmodule

@@ sv/keyed_list_with_free_slots_core.sv @@
// Keyed record list over a fixed slot store, with a free-slot chain: top level.
//
// One command is taken at a time; req_ready is high only while no command is in progress,
// although a last result may still sit in the output register. Each visited list slot
// takes a registered read of the record and link stores (S_READ), then the compare
// (S_CHECK), where a filter waits while a new match finds a held one and a busy output
// register. An insert of a new key then allocates a slot (S_ALLOC_RD finds the store full or
// reads the free head, S_ALLOC_WR writes the record, S_ALLOC_LINK links it at the tail), a delete
// unlinks and releases the slot, and rsp_ready may hold off any result. A filter holds each
// matching record until the next match or the end of the walk, so it can mark the final one.
// Codes 6 and 7 are accepted and dropped without a result. No clearing pass is needed after
// reset: link entries carry a written flag, and unwritten ones read as their reset chain.
module keyed_list_with_free_slots_core #(
   parameter int SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  klfs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output klfs_pkg::rsp_type rsp_data
);

   klfs_pkg::ctrl_cmd_type cmd;
   klfs_pkg::ctrl_sts_type sts;

   klfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   klfs_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
